// ===== hdl/fmf_pkg.sv =====
package fmf_pkg;

    // fixed field widths
    localparam int SAMPLE_W    = 16;
    localparam int POINT_W     = 16;
    localparam int POINT_COUNT = 4;
    localparam int SET_IDX_W   = 3;
    localparam int DEGREE_W    = 16;
    localparam int COUNT_W     = 3;
    localparam int OUT_DATA_W  = 24;

    // configuration port
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = POINT_W * POINT_COUNT;

    localparam logic [CFG_INDEX_W-1:0] REG_SHAPE_MODE  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ACTIVE_SETS = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_SET0_POINTS = 3'd2;

    localparam logic SHAPE_TRI  = 1'b0;
    localparam logic SHAPE_TRAP = 1'b1;

    localparam logic [COUNT_W-1:0] ACTIVE_SETS_RESET = 3'd1;

    // parameter defaults
    localparam int MAX_SETS_DEF      = 6;
    localparam int VALUE_BITS_DEF    = 16;
    localparam int FRACTION_BITS_DEF = 15;

    // controller to datapath
    typedef struct packed {
        logic load_value;
        logic setup;
        logic div_step;
        logic emit;
        logic next_set;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic last_set;
        logic out_free;
    } sts_t;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SETUP = 4'b0010,
        ST_DIV   = 4'b0100,
        ST_EMIT  = 4'b1000
    } state_t;

endpackage

// ===== hdl/fmf_cfg_regs.sv =====
module fmf_cfg_regs #(
    parameter int MAX_SETS = fmf_pkg::MAX_SETS_DEF
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        cfg_we,
    input  logic [fmf_pkg::CFG_INDEX_W-1:0]             cfg_index,
    input  logic [fmf_pkg::CFG_DATA_W-1:0]              cfg_wdata,
    output logic                                        shape_mode,
    output logic [fmf_pkg::COUNT_W-1:0]                 active_sets,
    output logic [MAX_SETS-1:0][fmf_pkg::CFG_DATA_W-1:0] set_points
);

    logic                                         shape_mode_reg;
    logic [fmf_pkg::COUNT_W-1:0]                  active_sets_reg;
    logic [MAX_SETS-1:0][fmf_pkg::CFG_DATA_W-1:0] set_points_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shape_mode_reg  <= fmf_pkg::SHAPE_TRI;
            active_sets_reg <= fmf_pkg::ACTIVE_SETS_RESET;
            set_points_reg  <= '0;
        end
        else if (cfg_we)
        begin
            if (cfg_index == fmf_pkg::REG_SHAPE_MODE)
                shape_mode_reg <= cfg_wdata[0];
            else if (cfg_index == fmf_pkg::REG_ACTIVE_SETS)
                active_sets_reg <= cfg_wdata[fmf_pkg::COUNT_W-1:0];
            else
            begin
                for (int i = 0; i < MAX_SETS; i++)
                begin
                    if (cfg_index == fmf_pkg::CFG_INDEX_W'(int'(fmf_pkg::REG_SET0_POINTS) + i))
                        set_points_reg[i] <= cfg_wdata;
                end
            end
        end
    end

    assign shape_mode  = shape_mode_reg;
    assign active_sets = active_sets_reg;
    assign set_points  = set_points_reg;

endmodule

// ===== hdl/fmf_ctrl.sv =====
module fmf_ctrl #(
    parameter int FRACTION_BITS = fmf_pkg::FRACTION_BITS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  fmf_pkg::sts_t sts,
    output fmf_pkg::cmd_t cmd
);

    localparam int STEP_W = $clog2(FRACTION_BITS + 1);

    fmf_pkg::state_t    state_reg, state_next;
    logic [STEP_W-1:0]  step_reg, step_next;

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            fmf_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_value = 1'b1;
                    state_next     = fmf_pkg::ST_SETUP;
                end
            end
            fmf_pkg::ST_SETUP:
            begin
                cmd.setup  = 1'b1;
                step_next  = '0;
                state_next = fmf_pkg::ST_DIV;
            end
            fmf_pkg::ST_DIV:
            begin
                cmd.div_step = 1'b1;
                step_next    = step_reg + 1'b1;
                if (step_reg == STEP_W'(FRACTION_BITS))
                    state_next = fmf_pkg::ST_EMIT;
            end
            fmf_pkg::ST_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (sts.last_set)
                        state_next = fmf_pkg::ST_IDLE;
                    else
                    begin
                        cmd.next_set = 1'b1;
                        state_next   = fmf_pkg::ST_SETUP;
                    end
                end
            end
            default:
            begin
                state_next = fmf_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fmf_pkg::ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

endmodule

// ===== hdl/fmf_datapath.sv =====
module fmf_datapath #(
    parameter int MAX_SETS      = fmf_pkg::MAX_SETS_DEF,
    parameter int VALUE_BITS    = fmf_pkg::VALUE_BITS_DEF,
    parameter int FRACTION_BITS = fmf_pkg::FRACTION_BITS_DEF
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  fmf_pkg::cmd_t                               cmd,
    output fmf_pkg::sts_t                               sts,
    input  logic [fmf_pkg::SAMPLE_W-1:0]                crisp_value,
    input  logic                                        shape_mode,
    input  logic [fmf_pkg::COUNT_W-1:0]                 active_sets,
    input  logic [MAX_SETS-1:0][fmf_pkg::CFG_DATA_W-1:0] set_points,
    input  logic                                        out_ready,
    output logic                                        out_valid,
    output logic [fmf_pkg::SET_IDX_W-1:0]               out_set_index,
    output logic [fmf_pkg::DEGREE_W-1:0]                out_degree,
    output logic                                        out_last
);

    localparam int VB = VALUE_BITS;
    localparam int QW = FRACTION_BITS + 1;
    localparam logic [QW-1:0] ONE_LEVEL = QW'(1) << FRACTION_BITS;

    logic signed [VB:0]               value_reg;
    logic [fmf_pkg::SET_IDX_W-1:0]    set_reg;
    logic [VB:0]                      rem_reg;
    logic [VB-1:0]                    div_reg;
    logic [QW-1:0]                    quot_reg;
    logic                             bypass_reg;
    logic [QW-1:0]                    fixed_reg;

    logic                             out_valid_reg;
    logic [fmf_pkg::SET_IDX_W-1:0]    out_set_reg;
    logic [fmf_pkg::DEGREE_W-1:0]     out_degree_reg;
    logic                             out_last_reg;

    logic [fmf_pkg::CFG_DATA_W-1:0]   pts;
    logic signed [VB:0]               p0, p1, p2, p3, p_end;
    logic signed [VB:0]               diff_w, diff_d;
    logic                             in_span, seg0, seg1, seg2;
    logic                             bypass_next;
    logic [QW-1:0]                    fixed_next;
    logic [VB-1:0]                    w_next, d_next;
    logic [fmf_pkg::COUNT_W-1:0]      count;
    logic                             q_bit;
    logic [VB:0]                      rem_sub;

    // clamp the active set count to 1..MAX_SETS
    always_comb
    begin
        if (active_sets == '0)
            count = fmf_pkg::COUNT_W'(1);
        else if (active_sets > fmf_pkg::COUNT_W'(MAX_SETS))
            count = fmf_pkg::COUNT_W'(MAX_SETS);
        else
            count = active_sets;
    end

    // breakpoints of the current set
    always_comb
    begin
        pts = '0;
        for (int i = 0; i < MAX_SETS; i++)
        begin
            if (set_reg == fmf_pkg::SET_IDX_W'(i))
                pts = set_points[i];
        end
    end

    assign p0 = {pts[VB-1], pts[VB-1:0]};
    assign p1 = {pts[fmf_pkg::POINT_W+VB-1], pts[fmf_pkg::POINT_W +: VB]};
    assign p2 = {pts[2*fmf_pkg::POINT_W+VB-1], pts[2*fmf_pkg::POINT_W +: VB]};
    assign p3 = {pts[3*fmf_pkg::POINT_W+VB-1], pts[3*fmf_pkg::POINT_W +: VB]};
    assign p_end = (shape_mode == fmf_pkg::SHAPE_TRAP) ? p3 : p2;

    assign in_span = (value_reg > p0) && (value_reg < p_end);
    assign seg0    = (value_reg >= p0) && (value_reg <= p1);
    assign seg1    = (value_reg >= p1) && (value_reg <= p2);
    assign seg2    = (shape_mode == fmf_pkg::SHAPE_TRAP) && (value_reg >= p2)
                     && (value_reg <= p3);

    // segment choice: slope operands or a fixed level
    always_comb
    begin
        bypass_next = 1'b1;
        fixed_next  = '0;
        diff_w      = '0;
        diff_d      = '0;
        if (!in_span)
            fixed_next = '0;
        else if (seg0)
        begin
            // rising edge, zero width keeps level 0
            diff_w = p1 - p0;
            diff_d = value_reg - p0;
            bypass_next = (diff_w == '0);
        end
        else if (seg1)
        begin
            if (shape_mode == fmf_pkg::SHAPE_TRAP)
                fixed_next = ONE_LEVEL;
            else
            begin
                // falling edge of the triangle
                diff_w = p2 - p1;
                diff_d = p2 - value_reg;
                fixed_next  = ONE_LEVEL;
                bypass_next = (diff_w == '0);
            end
        end
        else if (seg2)
        begin
            diff_w = p3 - p2;
            diff_d = p3 - value_reg;
            fixed_next  = ONE_LEVEL;
            bypass_next = (diff_w == '0);
        end
        else
            fixed_next = '0;
        w_next = diff_w[VB-1:0];
        d_next = diff_d[VB-1:0];
    end

    // one restoring division step
    assign q_bit   = (rem_reg >= {1'b0, div_reg});
    assign rem_sub = q_bit ? (rem_reg - {1'b0, div_reg}) : rem_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load_value)
            value_reg <= {crisp_value[VB-1], crisp_value[VB-1:0]};
        if (cmd.setup)
        begin
            rem_reg    <= {1'b0, d_next};
            div_reg    <= w_next;
            quot_reg   <= '0;
            bypass_reg <= bypass_next;
            fixed_reg  <= fixed_next;
        end
        else if (cmd.div_step)
        begin
            rem_reg  <= {rem_sub[VB-1:0], 1'b0};
            quot_reg <= {quot_reg[QW-2:0], q_bit};
        end
        if (cmd.emit)
        begin
            out_set_reg    <= set_reg;
            out_degree_reg <= fmf_pkg::DEGREE_W'(bypass_reg ? fixed_reg : quot_reg);
            out_last_reg   <= sts.last_set;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load_value)
                set_reg <= '0;
            else if (cmd.next_set)
                set_reg <= set_reg + 1'b1;
            if (cmd.emit)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign sts.last_set = (set_reg == count - 1'b1);
    assign sts.out_free = !out_valid_reg || out_ready;

    assign out_valid     = out_valid_reg;
    assign out_set_index = out_set_reg;
    assign out_degree    = out_degree_reg;
    assign out_last      = out_last_reg;

endmodule

// ===== hdl/fuzzy_membership_fuzzifier_core.sv =====
// fuzzy membership fuzzifier
// input stream: one word per crisp sample on s_axis, signed in the low bits
// output stream: one word per active fuzzy set on m_axis, in set order,
// carrying the set index and its Q1.15 membership degree; tlast marks the
// word of the last active set
// configuration: write cfg_wdata to register cfg_index while cfg_we is high,
// only while no sample is in flight; index 0 shape, 1 active set count,
// 2 and up the packed breakpoints of each set
// sequence: each set takes a setup step, the divide steps of the shared
// serial divider and an emit step, in which the output register takes
// the word of that set; a sample is taken in the idle state
// the divider is the one shared unit and sets its pace; a new sample is
// taken only once the previous one has issued all its words
// a stalled receiver holds the output register; the divider result for the
// next set then waits in the emit state until the word is taken
// reset clears the controller and the output valid flag and loads
// triangle mode, one active set and all breakpoints at zero
module fuzzy_membership_fuzzifier_core #(
    parameter int MAX_SETS      = fmf_pkg::MAX_SETS_DEF,
    parameter int VALUE_BITS    = fmf_pkg::VALUE_BITS_DEF,
    parameter int FRACTION_BITS = fmf_pkg::FRACTION_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // sample stream
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [fmf_pkg::SAMPLE_W-1:0]     s_axis_tdata,   // crisp_value[15:0]
    // degree stream
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [fmf_pkg::OUT_DATA_W-1:0]   m_axis_tdata,   // set_index[2:0], degree[18:3]
    output logic                             m_axis_tlast,
    // configuration writes
    input  logic                             cfg_we,
    input  logic [fmf_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [fmf_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    localparam int PAD_W = fmf_pkg::OUT_DATA_W - fmf_pkg::DEGREE_W - fmf_pkg::SET_IDX_W;

    fmf_pkg::cmd_t                                cmd;
    fmf_pkg::sts_t                                sts;
    logic                                         shape_mode;
    logic [fmf_pkg::COUNT_W-1:0]                  active_sets;
    logic [MAX_SETS-1:0][fmf_pkg::CFG_DATA_W-1:0] set_points;
    logic [fmf_pkg::SET_IDX_W-1:0]                out_set_index;
    logic [fmf_pkg::DEGREE_W-1:0]                 out_degree;

    // register file for shape, set count and breakpoints
    fmf_cfg_regs #(
        .MAX_SETS (MAX_SETS)
    ) u_cfg (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .shape_mode  (shape_mode),
        .active_sets (active_sets),
        .set_points  (set_points)
    );

    // sequencer: setup, divide, emit for each set
    fmf_ctrl #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // segment select, serial divider and output register
    fmf_datapath #(
        .MAX_SETS      (MAX_SETS),
        .VALUE_BITS    (VALUE_BITS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .crisp_value   (s_axis_tdata),
        .shape_mode    (shape_mode),
        .active_sets   (active_sets),
        .set_points    (set_points),
        .out_ready     (m_axis_tready),
        .out_valid     (m_axis_tvalid),
        .out_set_index (out_set_index),
        .out_degree    (out_degree),
        .out_last      (m_axis_tlast)
    );

    // pack the word, set index in the low bits
    assign m_axis_tdata = {{PAD_W{1'b0}}, out_degree, out_set_index};

endmodule
